### rtl/prfo_pkg.sv
package prfo_pkg;

   localparam int SLOTS     = 32;
   localparam int PKT_BYTES = 64;
   localparam int DEPTH     = SLOTS * PKT_BYTES;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int POS_W  = $clog2(PKT_BYTES + 1);
   localparam int IDX_W  = (PKT_BYTES > 1) ? $clog2(PKT_BYTES) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef struct packed {
      logic clear_we;
      logic push;
      logic pop_start;
      logic pop_run;
   } prfo_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pop_done;
   } prfo_status_type;

endpackage

### rtl/prfo_ifs.sv
interface prfo_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output req_type, output data_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input req_type, input data_byte, input last_byte,
                   output ready);
endinterface

interface prfo_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       end_of_packet;
   logic       found_packet;
   logic       more_waiting;

   modport source (output valid, output read_byte, output end_of_packet,
                   output found_packet, output more_waiting, input ready);
   modport sink   (input valid, input read_byte, input end_of_packet,
                   input found_packet, input more_waiting, output ready);
endinterface

### rtl/prfo_ctrl.sv
module prfo_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_type,
   output logic                      req_ready,
   input  prfo_pkg::prfo_status_type status,
   output prfo_pkg::prfo_cmd_type    cmd
);
   import prfo_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_POP   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd           = '0;
      cmd.clear_we  = (state_ff == ST_CLEAR);
      cmd.push      = accept && (req_type == REQ_PUSH);
      cmd.pop_start = accept && (req_type == REQ_POP);
      cmd.pop_run   = (state_ff == ST_POP);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.pop_start) state_in = ST_POP;
         end
         ST_POP: begin
            if (status.pop_done) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/prfo_datapath.sv
module prfo_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  prfo_pkg::prfo_cmd_type    cmd,
   output prfo_pkg::prfo_status_type status,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                read_byte,
   output logic                      end_of_packet,
   output logic                      found_packet,
   output logic                      more_waiting
);
   import prfo_pkg::*;

   localparam logic [ADDR_W-1:0] PKT_BYTES_A = ADDR_W'(PKT_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOTS - 1);
   localparam logic [POS_W-1:0]  PKT_BYTES_P = POS_W'(PKT_BYTES);
   localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(PKT_BYTES - 1);

   logic [7:0] mem [DEPTH];
   logic [7:0] mem_q;

   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [POS_W-1:0]  byte_pos_ff, byte_pos_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in;
   logic              found_ff, found_in;
   logic              more_ff, more_in;
   logic [POS_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_eop_ff, out_eop_in;
   logic              out_found_ff, out_found_in;
   logic              out_more_ff, out_more_in;

   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [7:0]        wdata;
   logic              re;
   logic [ADDR_W-1:0] raddr;

   logic [SLOT_W-1:0] wr_next, rd_next, wr_next_next;
   logic              pos_room;
   logic              out_free, load_out, issue_done, issue;
   logic [IDX_W-1:0]  issue_idx;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   assign wr_next      = slot_inc(wr_slot_ff);
   assign rd_next      = slot_inc(rd_slot_ff);
   assign wr_next_next = slot_inc(wr_next);
   assign pos_room     = (byte_pos_ff < PKT_BYTES_P);

   // write port: clearing pass or pushed byte
   always_comb begin
      if (cmd.clear_we) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
         wdata = 8'd0;
      end else begin
         we    = cmd.push && pos_room;
         waddr = ADDR_W'(wr_slot_ff) * PKT_BYTES_A + ADDR_W'(byte_pos_ff[IDX_W-1:0]);
         wdata = data_byte;
      end
   end

   // pop read pipeline: memory read stage, then output register
   assign out_free   = !out_valid_ff || rsp_ready;
   assign load_out   = cmd.pop_run && pend_ff && out_free;
   assign issue_done = found_ff ? (issue_cnt_ff == PKT_BYTES_P) : (issue_cnt_ff != '0);
   assign issue      = cmd.pop_run && !issue_done && (!pend_ff || load_out);
   assign issue_idx  = issue_cnt_ff[IDX_W-1:0];
   assign re         = issue;
   assign raddr      = ADDR_W'(base_slot_ff) * PKT_BYTES_A + ADDR_W'(issue_idx);

   assign status.clear_last = cmd.clear_we && (clr_addr_ff == LAST_ADDR);
   assign status.pop_done   = cmd.pop_run && issue_done && !pend_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) mem_q <= mem[raddr];
   end

   always_comb begin
      clr_addr_in  = cmd.clear_we ? clr_addr_ff + 1'b1 : clr_addr_ff;
      wr_slot_in   = wr_slot_ff;
      rd_slot_in   = rd_slot_ff;
      byte_pos_in  = byte_pos_ff;
      base_slot_in = base_slot_ff;
      found_in     = found_ff;
      more_in      = more_ff;
      issue_cnt_in = issue_cnt_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;

      if (cmd.push) begin
         if (pos_room) byte_pos_in = byte_pos_ff + 1'b1;
         if (last_byte) begin
            wr_slot_in  = wr_next;
            byte_pos_in = '0;
            if (wr_next == rd_slot_ff) rd_slot_in = wr_next_next;
         end
      end

      if (cmd.pop_start) begin
         base_slot_in = rd_slot_ff;
         found_in     = (wr_slot_ff != rd_slot_ff);
         more_in      = (wr_slot_ff != rd_slot_ff) && (wr_slot_ff != rd_next);
         if (wr_slot_ff != rd_slot_ff) rd_slot_in = rd_next;
         issue_cnt_in = '0;
         pend_in      = 1'b0;
      end else if (cmd.pop_run) begin
         if (issue) begin
            issue_cnt_in = issue_cnt_ff + 1'b1;
            pend_idx_in  = issue_idx;
         end
         pend_in = issue || (pend_ff && !load_out);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_eop_in   = out_eop_ff;
      out_found_in = out_found_ff;
      out_more_in  = out_more_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = found_ff ? mem_q : 8'd0;
         out_eop_in   = !found_ff || (pend_idx_ff == LAST_IDX);
         out_found_in = found_ff;
         out_more_in  = more_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         wr_slot_ff   <= '0;
         rd_slot_ff   <= '0;
         byte_pos_ff  <= '0;
         found_ff     <= 1'b0;
         issue_cnt_ff <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         wr_slot_ff   <= wr_slot_in;
         rd_slot_ff   <= rd_slot_in;
         byte_pos_ff  <= byte_pos_in;
         found_ff     <= found_in;
         issue_cnt_ff <= issue_cnt_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_slot_ff <= base_slot_in;
      more_ff      <= more_in;
      pend_idx_ff  <= pend_idx_in;
      out_byte_ff  <= out_byte_in;
      out_eop_ff   <= out_eop_in;
      out_found_ff <= out_found_in;
      out_more_ff  <= out_more_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign read_byte     = out_byte_ff;
   assign end_of_packet = out_eop_ff;
   assign found_packet  = out_found_ff;
   assign more_waiting  = out_more_ff;

endmodule

### rtl/packet_ring_fifo_overwrite_oldest.sv
// Packet ring FIFO, overwrite oldest on full.
// req_ch (sink): one transfer per push byte (req_type 0, data_byte, last_byte)
//   or per pop request (req_type 1). last_byte commits the packet being filled;
//   bytes past the slot size are dropped. When the ring is full the oldest
//   packet is discarded, so at most SLOTS-1 packets wait.
// rsp_ch (source): a pop returns PKT_BYTES transfers of the oldest slot with
//   end_of_packet on the final one, or a single transfer with found_packet 0
//   when nothing waits. more_waiting tells whether packets remain.
// Throughput: a pop holds the request side until its last transfer (the only
//   one for an empty pop) is in the output register; with rsp_ch ready,
//   the slot streams one byte per cycle through the single read port of
//   the packet store and an output register.
// Pop path: the pop state is entered, the store is read, the output register is loaded.
// Reset: the packet store is zeroed by a pass over its SLOTS*PKT_BYTES entries
//   (2048), one entry a cycle; req_ch.ready stays low until it ends.
// Stall: a low rsp_ch.ready holds the output register and the byte stream;
//   nothing is lost. A push may be taken while the last result still waits.
module packet_ring_fifo_overwrite_oldest (
   input logic        clock,
   input logic        reset,
   prfo_req_if.sink   req_ch,
   prfo_rsp_if.source rsp_ch
);
   import prfo_pkg::*;

   prfo_cmd_type    cmd;
   prfo_status_type status;

   prfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   prfo_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .data_byte     (req_ch.data_byte),
      .last_byte     (req_ch.last_byte),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .read_byte     (rsp_ch.read_byte),
      .end_of_packet (rsp_ch.end_of_packet),
      .found_packet  (rsp_ch.found_packet),
      .more_waiting  (rsp_ch.more_waiting)
   );

endmodule
